// ===== rtl/core/onsm_pkg.sv =====
package onsm_pkg;

    // Event codes carried on s_tuser
    typedef enum logic [3:0] {
        EV_HELLO       = 4'd0,
        EV_TWOWAY      = 4'd1,
        EV_NEGDONE     = 4'd2,
        EV_EXCHDONE    = 4'd3,
        EV_BADLSREQ    = 4'd4,
        EV_LOADDONE    = 4'd5,
        EV_ADJOK       = 4'd6,
        EV_SEQMISMATCH = 4'd7,
        EV_ONEWAY      = 4'd8,
        EV_KILL        = 4'd9,
        EV_INACTIVITY  = 4'd10,
        EV_LLDOWN      = 4'd11
    } event_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_DEAD_INTERVAL  = 3'd0,
        CFG_NETWORK_KIND   = 3'd1,
        CFG_OWN_ADDRESS    = 3'd2,
        CFG_DR_ADDRESS     = 3'd3,
        CFG_BDR_ADDRESS    = 3'd4,
        CFG_NEIGHBOR_ADDR  = 3'd5,
        CFG_STUB_AREA      = 3'd6,
        CFG_SEQUENCE_SEED  = 3'd7
    } cfg_idx_t;

    // Network kinds
    localparam logic [1:0] NET_BROADCAST = 2'd0;
    localparam logic [1:0] NET_VIRTUAL   = 2'd1;
    localparam logic [1:0] NET_OTHER     = 2'd2;

    // LSA origination requests
    localparam logic [1:0] ORIG_NONE    = 2'd0;
    localparam logic [1:0] ORIG_NETWORK = 2'd1;
    localparam logic [1:0] ORIG_REFRESH = 2'd2;

    // Options byte for DD exchange
    localparam logic [7:0] OPTIONS_STUB   = 8'h40;
    localparam logic [7:0] OPTIONS_NORMAL = 8'h42;

    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned IN_DATA_W  = 16;
    localparam int unsigned OUT_DATA_W = 72;

endpackage

// ===== rtl/core/ospf_neighbor_state_machine.sv =====
// OSPF neighbor state machine for one neighbor (Down, Attempt, Init, 2-Way,
// ExStart, Exchange, Loading, Full). Each input beat is one event; each event
// yields exactly one result beat with the new state, the DD sequence and
// options, the inactivity timer load value and the action flags. Events are
// taken one per clock cycle, back to back, unless a low m_tready stalls the
// result stream. An event passes an input register, then a single pass of
// next-state logic into the result register, which also updates the neighbor
// state that the following event sees. The user must write configuration via
// the cfg_* port while no event is in flight (not enforced); no read-back.
module ospf_neighbor_state_machine #(
    parameter int unsigned ADJ_FORMING_MAX = 4
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // configuration write port
    input  logic                                 cfg_wr_en,
    input  logic [2:0]                           cfg_index,
    input  logic [onsm_pkg::CFG_DATA_W-1:0]      cfg_data,
    // event stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // [0] request_list_empty, [8:1] forming_count, [15:9] zero
    input  logic [onsm_pkg::IN_DATA_W-1:0]       s_tdata,
    // [3:0] kind
    input  logic [3:0]                           s_tuser,
    // result stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [2:0] new_state, [3] state_changed, [4] send_trap, [5] start_dd_exchange,
    // [37:6] dd_sequence, [45:38] dd_options, [46] send_ls_request,
    // [47] clear_lists, [48] adjacency_postponed, [49] remove_neighbor,
    // [51:50] originate_lsas, [67:52] inact_load, [71:68] zero
    output logic [onsm_pkg::OUT_DATA_W-1:0]      m_tdata
);

    typedef enum logic [2:0] {
        ST_DOWN     = 3'd0,
        ST_ATTEMPT  = 3'd1,
        ST_INIT     = 3'd2,
        ST_TWOWAY   = 3'd3,
        ST_EXSTART  = 3'd4,
        ST_EXCHANGE = 3'd5,
        ST_LOADING  = 3'd6,
        ST_FULL     = 3'd7
    } nbr_state_t;

    // configuration registers
    logic [15:0] dead_interval_reg;
    logic [1:0]  network_kind_reg;
    logic [31:0] own_address_reg;
    logic [31:0] dr_address_reg;
    logic [31:0] bdr_address_reg;
    logic [31:0] neighbor_address_reg;
    logic        stub_area_reg;
    logic [31:0] sequence_seed_reg;

    // input stage
    logic        in_valid_reg;
    logic [3:0]  in_kind_reg;
    logic        in_req_empty_reg;
    logic [7:0]  in_forming_reg;

    // neighbor state
    nbr_state_t  state_reg, state_next;
    logic [15:0] inact_reg, inact_next;
    logic [31:0] dd_seq_reg, dd_seq_next;
    logic        master_reg, master_next;
    logic [7:0]  options_reg, options_next;
    logic        postponed_reg, postponed_next;

    // result stage
    logic        out_valid_reg;
    logic [onsm_pkg::OUT_DATA_W-1:0] out_data_reg, out_data_next;

    logic advance;
    logic load_in;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign load_in  = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // next-state and result logic for the event in the input register
    always_comb
    begin
        onsm_pkg::event_t ev;
        logic             adj;
        logic             changed;
        logic             trap;
        logic             start_dd;
        logic             ls_req;
        logic             clr;
        logic             remove;
        logic [1:0]       orig;
        logic             is_dr;
        logic [31:0]      seq_base;
        logic [31:0]      seq_start;
        logic [7:0]       opt_start;

        ev       = onsm_pkg::event_t'(in_kind_reg);
        adj      = (network_kind_reg == onsm_pkg::NET_VIRTUAL)
                || (neighbor_address_reg == dr_address_reg)
                || (neighbor_address_reg == bdr_address_reg)
                || (own_address_reg == dr_address_reg)
                || (own_address_reg == bdr_address_reg);
        is_dr    = (own_address_reg == dr_address_reg);
        start_dd = 1'b0;
        ls_req   = 1'b0;
        clr      = 1'b0;
        remove   = 1'b0;
        orig     = onsm_pkg::ORIG_NONE;

        // adjacency start: bump first on a restart, then seed if zero and bump
        seq_base = ((ev == onsm_pkg::EV_BADLSREQ) || (ev == onsm_pkg::EV_SEQMISMATCH))
                 ? dd_seq_reg + 32'd1 : dd_seq_reg;
        seq_start = ((seq_base == 32'd0) ? sequence_seed_reg : seq_base) + 32'd1;
        opt_start = stub_area_reg ? onsm_pkg::OPTIONS_STUB : onsm_pkg::OPTIONS_NORMAL;

        state_next     = state_reg;
        inact_next     = inact_reg;
        dd_seq_next    = dd_seq_reg;
        master_next    = master_reg;
        options_next   = options_reg;
        postponed_next = postponed_reg;

        unique case (ev) inside
            onsm_pkg::EV_HELLO:
            begin
                if (state_reg < ST_INIT)
                begin
                    state_next = ST_INIT;
                end
                inact_next = dead_interval_reg;
            end
            onsm_pkg::EV_TWOWAY:
            begin
                if (state_reg == ST_INIT)
                begin
                    if (adj)
                    begin
                        state_next   = ST_EXSTART;
                        dd_seq_next  = seq_start;
                        master_next  = 1'b1;
                        options_next = opt_start;
                        start_dd     = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_TWOWAY;
                    end
                end
            end
            onsm_pkg::EV_NEGDONE:
            begin
                if (state_reg == ST_EXSTART)
                begin
                    state_next = ST_EXCHANGE;
                end
            end
            onsm_pkg::EV_EXCHDONE:
            begin
                if (state_reg == ST_EXCHANGE)
                begin
                    if (in_req_empty_reg)
                    begin
                        state_next = ST_FULL;
                        orig       = is_dr ? onsm_pkg::ORIG_NETWORK : onsm_pkg::ORIG_NONE;
                    end
                    else
                    begin
                        state_next = ST_LOADING;
                        ls_req     = 1'b1;
                    end
                end
            end
            onsm_pkg::EV_LOADDONE:
            begin
                if (state_reg == ST_LOADING)
                begin
                    state_next = ST_FULL;
                    orig       = is_dr ? onsm_pkg::ORIG_NETWORK : onsm_pkg::ORIG_NONE;
                end
            end
            onsm_pkg::EV_ADJOK:
            begin
                if ((state_reg == ST_TWOWAY) && adj)
                begin
                    if (in_forming_reg >= 8'(ADJ_FORMING_MAX))
                    begin
                        postponed_next = 1'b1;
                    end
                    else
                    begin
                        postponed_next = 1'b0;
                        state_next     = ST_EXSTART;
                        dd_seq_next    = seq_start;
                        master_next    = 1'b1;
                        options_next   = opt_start;
                        start_dd       = 1'b1;
                    end
                end
                else if ((state_reg >= ST_EXSTART) && !adj)
                begin
                    clr        = 1'b1;
                    state_next = ST_TWOWAY;
                end
            end
            onsm_pkg::EV_BADLSREQ, onsm_pkg::EV_SEQMISMATCH:
            begin
                if (state_reg >= ST_EXCHANGE)
                begin
                    state_next   = ST_EXSTART;
                    dd_seq_next  = seq_start;
                    master_next  = 1'b1;
                    options_next = opt_start;
                    clr          = 1'b1;
                    start_dd     = 1'b1;
                end
            end
            onsm_pkg::EV_ONEWAY:
            begin
                if (state_reg >= ST_TWOWAY)
                begin
                    state_next = ST_INIT;
                    clr        = 1'b1;
                end
            end
            onsm_pkg::EV_KILL, onsm_pkg::EV_INACTIVITY, onsm_pkg::EV_LLDOWN:
            begin
                state_next     = ST_DOWN;
                inact_next     = 16'd0;
                master_next    = 1'b0;
                dd_seq_next    = 32'd0;
                postponed_next = 1'b0;
                clr            = 1'b1;
                if ((ev == onsm_pkg::EV_KILL)
                    || ((ev == onsm_pkg::EV_INACTIVITY)
                        && (network_kind_reg == onsm_pkg::NET_BROADCAST)))
                begin
                    remove = 1'b1;
                    orig   = onsm_pkg::ORIG_REFRESH;
                end
            end
            default:
            begin
                // unused event codes leave everything as it is
            end
        endcase

        changed = (state_next != state_reg);
        trap    = changed && ((state_next < state_reg) || (state_next == ST_TWOWAY)
                              || (state_next == ST_FULL));

        out_data_next = {4'd0, inact_next, orig, remove, postponed_next, clr, ls_req,
                         options_next, dd_seq_next, start_dd, trap, changed,
                         state_next};
    end

    // configuration, input stage, neighbor state and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dead_interval_reg    <= 16'd40;
            network_kind_reg     <= 2'd0;
            own_address_reg      <= 32'd0;
            dr_address_reg       <= 32'd0;
            bdr_address_reg      <= 32'd0;
            neighbor_address_reg <= 32'd0;
            stub_area_reg        <= 1'b0;
            sequence_seed_reg    <= 32'd1;
            in_valid_reg         <= 1'b0;
            in_kind_reg          <= 4'd0;
            in_req_empty_reg     <= 1'b0;
            in_forming_reg       <= 8'd0;
            state_reg            <= ST_DOWN;
            inact_reg            <= 16'd0;
            dd_seq_reg           <= 32'd0;
            master_reg           <= 1'b0;
            options_reg          <= 8'd0;
            postponed_reg        <= 1'b0;
            out_valid_reg        <= 1'b0;
            out_data_reg         <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (onsm_pkg::cfg_idx_t'(cfg_index))
                    onsm_pkg::CFG_DEAD_INTERVAL: dead_interval_reg    <= cfg_data[15:0];
                    onsm_pkg::CFG_NETWORK_KIND:  network_kind_reg     <= cfg_data[1:0];
                    onsm_pkg::CFG_OWN_ADDRESS:   own_address_reg      <= cfg_data;
                    onsm_pkg::CFG_DR_ADDRESS:    dr_address_reg       <= cfg_data;
                    onsm_pkg::CFG_BDR_ADDRESS:   bdr_address_reg      <= cfg_data;
                    onsm_pkg::CFG_NEIGHBOR_ADDR: neighbor_address_reg <= cfg_data;
                    onsm_pkg::CFG_STUB_AREA:     stub_area_reg        <= cfg_data[0];
                    onsm_pkg::CFG_SEQUENCE_SEED: sequence_seed_reg    <= cfg_data;
                endcase
            end

            // input beat capture
            if (load_in)
            begin
                in_valid_reg     <= 1'b1;
                in_kind_reg      <= s_tuser;
                in_req_empty_reg <= s_tdata[0];
                in_forming_reg   <= s_tdata[8:1];
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            // event moves into the result register
            if (advance)
            begin
                state_reg     <= state_next;
                inact_reg     <= inact_next;
                dd_seq_reg    <= dd_seq_next;
                master_reg    <= master_next;
                options_reg   <= options_next;
                postponed_reg <= postponed_next;
                out_data_reg  <= out_data_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule
